// ===== design/smig_pkg.sv =====
// Shared types and constants for the sphere mesh index generator.
// No dependencies; imported by every module of the block.
package smig_pkg;

    localparam int CFG_W       = 9;
    localparam int IDX_W       = 17;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;
    localparam int DEF_SECTORS = 16;
    localparam int DEF_RINGS   = 8;
    localparam int MAX_SECTORS_DEF = 256;
    localparam int MAX_RINGS_DEF   = 256;

    // Register index, taken from paddr[2]
    localparam logic REG_SECTORS = 1'b0;
    localparam logic REG_RINGS   = 1'b1;

    typedef enum logic [1:0] {
        PH_TOP  = 2'd0,
        PH_BAND = 2'd1,
        PH_BOT  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_a;
        logic [IDX_W-1:0] vertex_b;
        logic [IDX_W-1:0] vertex_c;
        phase_t           region;
        logic             last;
    } tri_t;

    typedef struct packed {
        logic advance;   // a word is taken this cycle
        logic restart;   // its restart field
        logic clear;     // register write: back to triangle 0
    } seq_ctrl_t;

endpackage

// ===== design/smig_seq.sv =====
// Sequencer: phase, band, sector and row base counters plus the triangle
// index arithmetic for the current word. Depends on smig_pkg.
module smig_seq
    import smig_pkg::*;
#(
    parameter int MAX_SECTORS = MAX_SECTORS_DEF,
    parameter int MAX_RINGS   = MAX_RINGS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  seq_ctrl_t        ctrl,
    input  logic [CFG_W-1:0] sector_count,
    input  logic [CFG_W-1:0] ring_count,
    output tri_t             tri_out
);

    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int SMAX    = (MAX_SECTORS < CFG_MAX) ? MAX_SECTORS : CFG_MAX;
    localparam int RMAX    = (MAX_RINGS < CFG_MAX) ? MAX_RINGS : CFG_MAX;
    localparam int CW      = $clog2(SMAX);
    localparam int BW      = (RMAX > 2) ? $clog2(RMAX) : 1;
    localparam int CMP_W   = CFG_W + 1;

    phase_t           phase_reg, phase_next;
    logic [BW-1:0]    band_reg, band_next;
    logic [CW-1:0]    sector_reg, sector_next;
    logic             half_reg, half_next;
    logic [IDX_W-1:0] row_base_reg, row_base_next;

    logic [CFG_W-1:0] s, r;
    logic             clr;
    phase_t           ph;
    logic [CW-1:0]    j;
    logic [BW-1:0]    band;
    logic             half;
    logic [IDX_W-1:0] rb, s17, j17, nb;
    logic [IDX_W-1:0] rbj, rbj1, nbj, nbj1, sj, sj1;
    logic [CMP_W-1:0] j_inc, band_inc, r_m2;
    logic             wrap, band_done;

    always_comb
    begin
        s = sector_count;
        if (s == '0)
            s = CFG_W'(1);
        else if (CMP_W'(s) > CMP_W'(SMAX))
            s = CFG_W'(SMAX);
        r = ring_count;
        if (r < CFG_W'(2))
            r = CFG_W'(2);
        else if (CMP_W'(r) > CMP_W'(RMAX))
            r = CFG_W'(RMAX);
    end

    // The restart field, phase code 3 or a sector index past a shrunk S restarts the sequence
    assign clr  = ctrl.restart
               || !(phase_reg == PH_TOP || phase_reg == PH_BAND || phase_reg == PH_BOT)
               || (CMP_W'(sector_reg) >= CMP_W'(s));
    assign ph   = clr ? PH_TOP : phase_reg;
    assign j    = clr ? '0 : sector_reg;
    assign band = clr ? '0 : band_reg;
    assign half = clr ? 1'b0 : half_reg;
    assign rb   = clr ? '0 : row_base_reg;

    assign s17  = IDX_W'(s);
    assign j17  = IDX_W'(j);
    assign nb   = rb + s17 + IDX_W'(1);
    assign rbj  = rb + j17;
    assign rbj1 = rbj + IDX_W'(1);
    assign nbj  = nb + j17;
    assign nbj1 = nbj + IDX_W'(1);
    assign sj   = s17 + j17;
    assign sj1  = sj + IDX_W'(1);

    assign j_inc     = CMP_W'(j) + CMP_W'(1);
    assign wrap      = j_inc >= CMP_W'(s);
    assign band_inc  = CMP_W'(band) + CMP_W'(1);
    assign r_m2      = CMP_W'(r) - CMP_W'(2);
    assign band_done = band_inc >= r_m2;

    // Next state
    always_comb
    begin
        phase_next    = ph;
        band_next     = band;
        sector_next   = j;
        half_next     = half;
        row_base_next = rb;
        unique case (ph)
            PH_TOP:
            begin
                sector_next = j_inc[CW-1:0];
                if (wrap)
                begin
                    sector_next   = '0;
                    row_base_next = s17;
                    phase_next    = (r > CFG_W'(2)) ? PH_BAND : PH_BOT;
                end
            end
            PH_BAND:
            begin
                if (!half)
                    half_next = 1'b1;
                else
                begin
                    half_next   = 1'b0;
                    sector_next = j_inc[CW-1:0];
                    if (wrap)
                    begin
                        sector_next   = '0;
                        row_base_next = nb;
                        band_next     = band_inc[BW-1:0];
                        if (band_done)
                        begin
                            band_next  = '0;
                            phase_next = PH_BOT;
                        end
                    end
                end
            end
            PH_BOT:
            begin
                sector_next = j_inc[CW-1:0];
                if (wrap)
                begin
                    phase_next    = PH_TOP;
                    band_next     = '0;
                    sector_next   = '0;
                    half_next     = 1'b0;
                    row_base_next = '0;
                end
            end
            default:
            begin
                phase_next    = PH_TOP;
                band_next     = '0;
                sector_next   = '0;
                half_next     = 1'b0;
                row_base_next = '0;
            end
        endcase
    end

    // Triangle for the current state
    always_comb
    begin
        tri_out.region = ph;
        tri_out.last   = 1'b0;
        unique case (ph)
            PH_TOP:
            begin
                tri_out.vertex_a = j17;
                tri_out.vertex_b = sj;
                tri_out.vertex_c = sj1;
            end
            PH_BAND:
            begin
                if (!half)
                begin
                    tri_out.vertex_a = rbj;
                    tri_out.vertex_b = nbj;
                    tri_out.vertex_c = nbj1;
                end
                else
                begin
                    tri_out.vertex_a = nbj1;
                    tri_out.vertex_b = rbj1;
                    tri_out.vertex_c = rbj;
                end
            end
            PH_BOT:
            begin
                tri_out.vertex_a = nbj;
                tri_out.vertex_b = rbj1;
                tri_out.vertex_c = rbj;
                tri_out.last     = wrap;
            end
            default:
            begin
                tri_out.vertex_a = '0;
                tri_out.vertex_b = '0;
                tri_out.vertex_c = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TOP;
            band_reg     <= '0;
            sector_reg   <= '0;
            half_reg     <= 1'b0;
            row_base_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            phase_reg    <= PH_TOP;
            band_reg     <= '0;
            sector_reg   <= '0;
            half_reg     <= 1'b0;
            row_base_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            phase_reg    <= phase_next;
            band_reg     <= band_next;
            sector_reg   <= sector_next;
            half_reg     <= half_next;
            row_base_reg <= row_base_next;
        end
    end

endmodule

// ===== design/sphere_mesh_index_generator.sv =====
// Top level of the sphere mesh index generator: register port, sequencer
// and output register. Depends on smig_pkg and smig_seq.
//
// Emits the triangle index list of a UV sphere, one triangle per input word.
// Input channel: in_valid/in_stall carrying restart; restart=1 makes the
// word produce the first top-cap triangle. Output channel: out_valid/
// out_stall carrying vertex_a/b/c, region and last; last marks the final
// bottom-cap triangle, after which the sequence starts over.
// A taken word shows its triangle in the cycle after. Throughput is one
// triangle per cycle while the receiver does not stall, set by the single
// output register; a new word is taken whenever that register is empty or
// being emptied in the same cycle. While the receiver stalls, the output
// holds and in_stall rises once the output register is full.
// Registers over APB: 0x0 sector_count, 0x4 ring_count (9 bits). A write
// returns the sequence to triangle 0; write only while idle.
// Reset: sector_count 16, ring_count 8, sequence at triangle 0, output
// empty.
module sphere_mesh_index_generator
    import smig_pkg::*;
#(
    parameter int MAX_SECTORS = MAX_SECTORS_DEF,
    parameter int MAX_RINGS   = MAX_RINGS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              restart,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  vertex_a,
    output logic [IDX_W-1:0]  vertex_b,
    output logic [IDX_W-1:0]  vertex_c,
    output logic [1:0]        region,
    output logic              last
);

    logic [CFG_W-1:0] sector_count_reg, ring_count_reg;
    logic             cfg_wr;
    logic             in_take;
    seq_ctrl_t        ctrl;
    tri_t             tri_cur;
    tri_t             tri_reg;
    logic             out_valid_reg, out_valid_next;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_count_reg <= CFG_W'(DEF_SECTORS);
            ring_count_reg   <= CFG_W'(DEF_RINGS);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SECTORS: sector_count_reg <= pwdata[CFG_W-1:0];
                REG_RINGS:   ring_count_reg   <= pwdata[CFG_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SECTORS: prdata = DATA_W'(sector_count_reg);
            REG_RINGS:   prdata = DATA_W'(ring_count_reg);
            default:     prdata = '0;
        endcase
    end

    assign in_stall = out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    assign ctrl.advance = in_take;
    assign ctrl.restart = restart;
    assign ctrl.clear   = cfg_wr;

    smig_seq #(
        .MAX_SECTORS (MAX_SECTORS),
        .MAX_RINGS   (MAX_RINGS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .sector_count (sector_count_reg),
        .ring_count   (ring_count_reg),
        .tri_out      (tri_cur)
    );

    assign out_valid_next = in_take || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            tri_reg <= tri_cur;
    end

    assign out_valid = out_valid_reg;
    assign vertex_a  = tri_reg.vertex_a;
    assign vertex_b  = tri_reg.vertex_b;
    assign vertex_c  = tri_reg.vertex_c;
    assign region    = tri_reg.region;
    assign last      = tri_reg.last;

endmodule

// ===== design/smig_checker.sv =====
// Port-level checks for the sphere mesh index generator, bound to the top.
// Depends on smig_pkg and sphere_mesh_index_generator.
module smig_checker
    import smig_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             restart,
    input logic             out_valid,
    input logic             out_stall,
    input logic [IDX_W-1:0] vertex_a,
    input logic [IDX_W-1:0] vertex_b,
    input logic [IDX_W-1:0] vertex_c,
    input logic [1:0]       region,
    input logic             last
);

    // Stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex_a)
            && $stable(vertex_b) && $stable(vertex_c) && $stable(region)
            && $stable(last))
        else $error("stalled output word changed");

    // Input backs up only behind a full, stalled output register
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in output");

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted word gave no triangle");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && restart |=> vertex_a == '0
            && region == PH_TOP && !last)
        else $error("restart did not give first top-cap triangle");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> region == PH_BOT)
        else $error("last flagged outside bottom cap");

endmodule

bind sphere_mesh_index_generator smig_checker u_smig_checker (.*);
